@@ hw/rtl/bmf_pkg.sv @@
package bmf_pkg;

  // Width of the block count register and of the byte fields.
  localparam int unsigned COUNT_REG_BITS = 9;
  localparam int unsigned WORD_BITS      = 32;

  // Depth of the command queue between the front and back parts.
  localparam int unsigned CMD_QUEUE_DEPTH = 2;

  // Default parameter values.
  localparam int unsigned MAX_BLOCKS_DEFAULT = 256;
  localparam int unsigned ADDR_BITS_DEFAULT  = 32;

  // Block size shift limits and reset value.
  localparam logic [4:0] SHIFT_MIN   = 5'd4;
  localparam logic [4:0] SHIFT_MAX   = 5'd20;
  localparam logic [4:0] SHIFT_RESET = 5'd10;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ENABLE      = 2'd0,
    REG_REGION_BASE = 2'd1,
    REG_BLOCK_COUNT = 2'd2,
    REG_BLOCK_SHIFT = 2'd3
  } reg_index_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DISABLED = 3'd1,
    ST_ZERO     = 3'd2,
    ST_NOSPACE  = 3'd3,
    ST_RANGE    = 3'd4,
    ST_ALIGN    = 3'd5,
    ST_NOTHEAD  = 3'd6,
    ST_FREE     = 3'd7
  } status_t;

  // Map entry codes.
  typedef enum logic [1:0] {
    ENTRY_EMPTY = 2'b00,
    ENTRY_HEAD  = 2'b01,
    ENTRY_TAIL  = 2'b10
  } entry_t;

  // What the back part has to do with a queued command.
  typedef enum logic [1:0] {
    CMD_RESULT = 2'd0,
    CMD_ALLOC  = 2'd1,
    CMD_FREE   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    status_t   status;
  } cmd_t;

  // Effective configuration seen by both parts.
  typedef struct packed {
    logic                 enable;
    logic [WORD_BITS-1:0] base;
    logic [4:0]           shift;
  } cfg_t;

  // Back part sequencer states.
  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_SCAN,
    BK_MARK,
    BK_FREE_RD,
    BK_FREE_CHK,
    BK_FREE_TAIL,
    BK_DONE
  } back_state_t;

  // Mask of the address bits kept, cut to the 32-bit field.
  function automatic logic [WORD_BITS-1:0] addr_mask(input int unsigned bits);
    logic [63:0] full_mask;
    full_mask = (bits >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << bits) - 64'd1);
    return full_mask[WORD_BITS-1:0];
  endfunction

endpackage

@@ hw/rtl/block_map_first_fit_allocator.sv @@
// First-fit block allocator over a map of fixed-size blocks.
// Requests come in on a queue-style port: drive opcode, request_bytes and
// free_address with push high; the transfer happens on a clock edge with full
// low. Results leave the same way: while empty is low, status and
// block_address show the oldest result, taken on an edge with pop high.
// Configuration uses cfg_we, cfg_index and cfg_data; the user must write it only
// while no request is in flight, as the block itself does not enforce this.
// A front stage checks each request and queues it (two entries); a back
// sequencer walks the block map, one entry per cycle on the map memory's
// single read and write ports. The back part works on one request at a
// time; further requests wait in the queue until its walk is done.
// After reset, and after each block_count write, a clearing pass writes
// every map entry empty; full stays high meanwhile.
// When pop is held low, the result waits, the queue fills, and full rises.
module block_map_first_fit_allocator #(
  parameter int unsigned MAX_BLOCKS = bmf_pkg::MAX_BLOCKS_DEFAULT,
  parameter int unsigned ADDR_BITS  = bmf_pkg::ADDR_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        opcode,
  input  logic [31:0] request_bytes,
  input  logic [31:0] free_address,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status,
  output logic [31:0] block_address,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned QW = $bits(bmf_pkg::cmd_t) + CW;

  logic                                  enable;
  logic [31:0]                           region_base;
  logic [bmf_pkg::COUNT_REG_BITS-1:0]    block_count;
  logic [4:0]                            block_shift;
  bmf_pkg::cfg_t                         cfg;
  logic [CW-1:0]                         count;
  logic                                  clear_req;
  logic                                  clearing;

  logic                                  q_push;
  logic                                  q_full;
  bmf_pkg::cmd_t                         q_hdr;
  logic [CW-1:0]                         q_arg;
  logic [QW-1:0]                         q_dout;
  logic                                  q_valid;
  logic                                  q_pop;
  bmf_pkg::cmd_t                         cmd_hdr;
  logic [CW-1:0]                         cmd_arg;
  bmf_pkg::status_t                      back_status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b0;
      region_base <= '0;
      block_count <= '0;
      block_shift <= bmf_pkg::SHIFT_RESET;
    end else if (cfg_we) begin
      unique case (bmf_pkg::reg_index_t'(cfg_index))
        bmf_pkg::REG_ENABLE:      enable      <= cfg_data[0];
        bmf_pkg::REG_REGION_BASE: region_base <= cfg_data;
        bmf_pkg::REG_BLOCK_COUNT: block_count <= cfg_data[bmf_pkg::COUNT_REG_BITS-1:0];
        bmf_pkg::REG_BLOCK_SHIFT: block_shift <= cfg_data[4:0];
      endcase
    end
  end

  assign clear_req = cfg_we && (cfg_index == bmf_pkg::REG_BLOCK_COUNT);

  // Effective block count and size after clamping.
  always_comb begin
    cfg.enable = enable;
    cfg.base   = region_base;
    if (block_shift < bmf_pkg::SHIFT_MIN) begin
      cfg.shift = bmf_pkg::SHIFT_MIN;
    end else if (block_shift > bmf_pkg::SHIFT_MAX) begin
      cfg.shift = bmf_pkg::SHIFT_MAX;
    end else begin
      cfg.shift = block_shift;
    end
    count = (32'(block_count) > 32'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(block_count);
  end

  bmf_front #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .push         (push),
    .full         (full),
    .opcode       (opcode),
    .request_bytes(request_bytes),
    .free_address (free_address),
    .cfg          (cfg),
    .count        (count),
    .clearing     (clearing),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_hdr        (q_hdr),
    .q_arg        (q_arg)
  );

  bmf_cmd_fifo #(
    .W    (QW),
    .DEPTH(bmf_pkg::CMD_QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  ({q_hdr, q_arg}),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_dout),
    .valid(q_valid)
  );

  assign {cmd_hdr, cmd_arg} = q_dout;

  bmf_back #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .count        (count),
    .clear_req    (clear_req),
    .clearing     (clearing),
    .cmd_valid    (q_valid),
    .cmd_hdr      (cmd_hdr),
    .cmd_arg      (cmd_arg),
    .cmd_pop      (q_pop),
    .empty        (empty),
    .pop          (pop),
    .status       (back_status),
    .block_address(block_address)
  );

  assign status = back_status;

  // A failed or free result never carries an address.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && (status != bmf_pkg::ST_OK)) |-> (block_address == '0))
    else $error("failed result carries a nonzero address");

  // The front never pushes into a full queue.
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("command queue overflow");

  // A block count write stops transfers while the map is cleared.
  assert property (@(posedge clk) disable iff (rst) clear_req |=> full)
    else $error("transfer possible during map clearing");

  // The back part only takes a command when one is queued.
  assert property (@(posedge clk) disable iff (rst) q_pop |-> (q_valid && !clearing))
    else $error("command taken from an empty queue");

endmodule

@@ hw/rtl/bmf_cmd_fifo.sv @@
module bmf_cmd_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = bmf_pkg::CMD_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         valid
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

  logic [W-1:0]  slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign full    = (fill == NW'(DEPTH));
  assign valid   = (fill != '0);
  assign dout    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Pointer and fill count update.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + NW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - NW'(1);
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

@@ hw/rtl/bmf_front.sv @@
module bmf_front #(
  parameter int unsigned MAX_BLOCKS = bmf_pkg::MAX_BLOCKS_DEFAULT,
  parameter int unsigned ADDR_BITS  = bmf_pkg::ADDR_BITS_DEFAULT,
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1),
  localparam int unsigned IW = $clog2(MAX_BLOCKS)
) (
  input  logic          push,
  output logic          full,
  input  logic          opcode,
  input  logic [31:0]   request_bytes,
  input  logic [31:0]   free_address,
  input  bmf_pkg::cfg_t cfg,
  input  logic [CW-1:0] count,
  input  logic          clearing,
  input  logic          q_full,
  output logic          q_push,
  output bmf_pkg::cmd_t q_hdr,
  output logic [CW-1:0] q_arg
);

  localparam logic [31:0] AMASK = bmf_pkg::addr_mask(ADDR_BITS);

  logic [31:0] need_blocks;
  logic [31:0] masked_addr;
  logic [32:0] offset_diff;
  logic [31:0] offset;
  logic [63:0] region_bytes;
  logic [31:0] align_mask;
  logic [31:0] block_index;

  // No transfer while the map is being cleared or the queue has no room.
  assign full   = q_full || clearing;
  assign q_push = push && !full;

  // Request arithmetic: run length in blocks and offset into the region.
  always_comb begin
    need_blocks  = ((request_bytes - 32'd1) >> cfg.shift) + 32'd1;
    masked_addr  = free_address & AMASK;
    offset_diff  = {1'b0, masked_addr} - {1'b0, cfg.base};
    offset       = offset_diff[31:0];
    region_bytes = 64'(count) << cfg.shift;
    align_mask   = (32'd1 << cfg.shift) - 32'd1;
    block_index  = offset >> cfg.shift;
  end

  // Decide everything that does not need the map; the rest goes to the back part.
  always_comb begin
    q_hdr.kind   = bmf_pkg::CMD_RESULT;
    q_hdr.status = bmf_pkg::ST_OK;
    q_arg        = '0;
    priority if (!cfg.enable) begin
      q_hdr.status = bmf_pkg::ST_DISABLED;
    end else if (!opcode) begin
      priority if (request_bytes == '0) begin
        q_hdr.status = bmf_pkg::ST_ZERO;
      end else if (need_blocks > 32'(count)) begin
        q_hdr.status = bmf_pkg::ST_NOSPACE;
      end else begin
        q_hdr.kind = bmf_pkg::CMD_ALLOC;
        q_arg      = CW'(need_blocks);
      end
    end else begin
      priority if (offset_diff[32] || (64'(offset) >= region_bytes)) begin
        q_hdr.status = bmf_pkg::ST_RANGE;
      end else if ((offset & align_mask) != '0) begin
        q_hdr.status = bmf_pkg::ST_ALIGN;
      end else begin
        q_hdr.kind = bmf_pkg::CMD_FREE;
        q_arg      = CW'(block_index[IW-1:0]);
      end
    end
  end

endmodule

@@ hw/rtl/bmf_back.sv @@
module bmf_back #(
  parameter int unsigned MAX_BLOCKS = bmf_pkg::MAX_BLOCKS_DEFAULT,
  parameter int unsigned ADDR_BITS  = bmf_pkg::ADDR_BITS_DEFAULT,
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1),
  localparam int unsigned IW = $clog2(MAX_BLOCKS)
) (
  input  logic            clk,
  input  logic            rst,
  input  bmf_pkg::cfg_t   cfg,
  input  logic [CW-1:0]   count,
  input  logic            clear_req,
  output logic            clearing,
  input  logic            cmd_valid,
  input  bmf_pkg::cmd_t   cmd_hdr,
  input  logic [CW-1:0]   cmd_arg,
  output logic            cmd_pop,
  output logic            empty,
  input  logic            pop,
  output bmf_pkg::status_t status,
  output logic [31:0]     block_address
);

  localparam logic [31:0]   AMASK   = bmf_pkg::addr_mask(ADDR_BITS);
  localparam logic [IW-1:0] CP_LAST = IW'(MAX_BLOCKS - 1);

  bmf_pkg::back_state_t state;
  bmf_pkg::back_state_t state_next;

  // Block map storage.
  logic [1:0]    map_mem [MAX_BLOCKS];
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [1:0]    mem_wd;
  logic [IW-1:0] mem_ra;
  logic [1:0]    rdata;

  // Walk state.
  logic [IW-1:0] cp;
  logic [CW-1:0] ra;
  logic          rv;
  logic [CW-1:0] pidx;
  logic [CW-1:0] run;
  logic [CW-1:0] run_new;
  logic [CW-1:0] need;
  logic [IW-1:0] idx;
  logic [IW-1:0] wp;
  logic [IW-1:0] endp;
  logic [IW-1:0] res_start;
  logic          res_addr_ok;
  bmf_pkg::status_t res_status;
  logic          issue;
  logic          hit;
  logic          last;
  logic          tail_end;
  logic          out_load;

  // Result register.
  logic          out_valid;

  assign clearing = (state == bmf_pkg::BK_CLEAR);
  assign empty    = !out_valid;
  assign out_load = (state == bmf_pkg::BK_DONE) && (!out_valid || pop);

  // Walk conditions.
  always_comb begin
    issue    = (ra < count);
    run_new  = (rdata == bmf_pkg::ENTRY_EMPTY) ? run + CW'(1) : '0;
    hit      = rv && (run_new == need);
    last     = rv && ((pidx + CW'(1)) == count);
    tail_end = (rv && (rdata != bmf_pkg::ENTRY_TAIL)) || (!rv && !issue);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      bmf_pkg::BK_CLEAR: begin
        if (cp == CP_LAST) state_next = bmf_pkg::BK_IDLE;
      end
      bmf_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          case (cmd_hdr.kind)
            bmf_pkg::CMD_ALLOC: state_next = bmf_pkg::BK_SCAN;
            bmf_pkg::CMD_FREE:  state_next = bmf_pkg::BK_FREE_RD;
            default:            state_next = bmf_pkg::BK_DONE;
          endcase
        end
      end
      bmf_pkg::BK_SCAN: begin
        if (hit) begin
          state_next = bmf_pkg::BK_MARK;
        end else if (last) begin
          state_next = bmf_pkg::BK_DONE;
        end
      end
      bmf_pkg::BK_MARK: begin
        if (wp == endp) state_next = bmf_pkg::BK_DONE;
      end
      bmf_pkg::BK_FREE_RD: begin
        state_next = bmf_pkg::BK_FREE_CHK;
      end
      bmf_pkg::BK_FREE_CHK: begin
        state_next = (rdata == bmf_pkg::ENTRY_HEAD) ? bmf_pkg::BK_FREE_TAIL
                                                    : bmf_pkg::BK_DONE;
      end
      bmf_pkg::BK_FREE_TAIL: begin
        if (tail_end) state_next = bmf_pkg::BK_DONE;
      end
      bmf_pkg::BK_DONE: begin
        if (!out_valid || pop) state_next = bmf_pkg::BK_IDLE;
      end
    endcase
    // A block count write restarts the clearing pass.
    if (clear_req) state_next = bmf_pkg::BK_CLEAR;
  end

  // Map port controls and queue pop.
  always_comb begin
    mem_we  = 1'b0;
    mem_wa  = wp;
    mem_wd  = bmf_pkg::ENTRY_EMPTY;
    mem_ra  = ra[IW-1:0];
    cmd_pop = 1'b0;
    unique case (state)
      bmf_pkg::BK_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = cp;
      end
      bmf_pkg::BK_IDLE: begin
        cmd_pop = cmd_valid;
      end
      bmf_pkg::BK_MARK: begin
        mem_we = 1'b1;
        mem_wa = wp;
        mem_wd = (wp == res_start) ? bmf_pkg::ENTRY_HEAD : bmf_pkg::ENTRY_TAIL;
      end
      bmf_pkg::BK_FREE_RD: begin
        mem_ra = idx;
      end
      bmf_pkg::BK_FREE_CHK: begin
        mem_we = (rdata == bmf_pkg::ENTRY_HEAD);
        mem_wa = idx;
      end
      bmf_pkg::BK_FREE_TAIL: begin
        mem_we = rv && (rdata == bmf_pkg::ENTRY_TAIL);
        mem_wa = pidx[IW-1:0];
      end
      bmf_pkg::BK_SCAN, bmf_pkg::BK_DONE: begin
      end
    endcase
  end

  // Map write port and registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_wa] <= mem_wd;
    end
    rdata <= map_mem[mem_ra];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bmf_pkg::BK_CLEAR;
      cp        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clear_req) begin
        cp <= '0;
      end else if (state == bmf_pkg::BK_CLEAR && cp != CP_LAST) begin
        cp <= cp + IW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Walk datapath and result payload.
  always_ff @(posedge clk) begin
    unique case (state)
      bmf_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          need        <= cmd_arg;
          idx         <= cmd_arg[IW-1:0];
          ra          <= '0;
          rv          <= 1'b0;
          run         <= '0;
          res_status  <= cmd_hdr.status;
          res_addr_ok <= 1'b0;
        end
      end
      bmf_pkg::BK_SCAN: begin
        rv   <= issue;
        pidx <= ra;
        if (issue) ra <= ra + CW'(1);
        if (rv) run <= run_new;
        if (hit) begin
          res_start <= IW'(pidx + CW'(1) - need);
          wp        <= IW'(pidx + CW'(1) - need);
          endp      <= pidx[IW-1:0];
        end else if (last) begin
          res_status <= bmf_pkg::ST_NOSPACE;
        end
      end
      bmf_pkg::BK_MARK: begin
        wp <= wp + IW'(1);
        if (wp == endp) begin
          res_status  <= bmf_pkg::ST_OK;
          res_addr_ok <= 1'b1;
        end
      end
      bmf_pkg::BK_FREE_CHK: begin
        ra <= CW'(idx) + CW'(1);
        rv <= 1'b0;
        if (rdata == bmf_pkg::ENTRY_HEAD) begin
          res_status <= bmf_pkg::ST_OK;
        end else if (rdata == bmf_pkg::ENTRY_EMPTY) begin
          res_status <= bmf_pkg::ST_FREE;
        end else begin
          res_status <= bmf_pkg::ST_NOTHEAD;
        end
      end
      bmf_pkg::BK_FREE_TAIL: begin
        rv   <= issue;
        pidx <= ra;
        if (issue) ra <= ra + CW'(1);
      end
      bmf_pkg::BK_DONE: begin
        if (out_load) begin
          status        <= res_status;
          block_address <= res_addr_ok
                         ? ((cfg.base + (32'(res_start) << cfg.shift)) & AMASK) : '0;
        end
      end
      bmf_pkg::BK_CLEAR, bmf_pkg::BK_FREE_RD: begin
      end
    endcase
  end

endmodule
